FILE: rtl/core/stc_pkg.sv
`timescale 1ns / 1ps

package stc_pkg;

    localparam int TABLE_LEN = 12;
    localparam int RECIP_SHIFT = 32;

    localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    // request to the shared multiplier: (a*b) >> shift, rounded and saturated
    typedef struct packed {
        logic               start;
        logic               q32;    // 1: shift by 32, 0: shift by the angle fraction
        logic signed [63:0] a;
        logic signed [63:0] b;
    } stc_mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] result;
    } stc_mul_rsp_t;

    // round(2^32 / ((2k+2)(2k+3))): ratio between successive reciprocal factorials
    function automatic logic [31:0] stc_ratio_recip(input logic [3:0] idx);
        logic [31:0] r;
        case (idx)
            4'd0:    r = 32'd715827883;
            4'd1:    r = 32'd214748365;
            4'd2:    r = 32'd102261126;
            4'd3:    r = 32'd59652324;
            4'd4:    r = 32'd39045157;
            4'd5:    r = 32'd27531842;
            4'd6:    r = 32'd20452225;
            4'd7:    r = 32'd15790321;
            4'd8:    r = 32'd12558384;
            4'd9:    r = 32'd10226113;
            4'd10:   r = 32'd8488078;
            4'd11:   r = 32'd7158279;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/stc_mul_unit.sv
`timescale 1ns / 1ps

module stc_mul_unit #(
    parameter int FRAC_BITS = 28
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stc_pkg::stc_mul_req_t req,
    output stc_pkg::stc_mul_rsp_t rsp
);
    import stc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_FIN
    } state_t;

    state_t       state_reg;
    logic [63:0]  mag_a_reg;
    logic [63:0]  mag_b_reg;
    logic         neg_reg;
    logic         q32_reg;
    logic [3:0]   mask_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_off_reg;
    logic         pp_valid_reg;
    logic [127:0] acc_reg;
    logic         done_reg;
    logic signed [63:0] result_reg;

    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [1:0]   sel;
    logic [3:0]   mask_left;
    logic [31:0]  op_a;
    logic [31:0]  op_b;
    logic [127:0] pp_shifted;
    logic [127:0] acc_sum;
    logic [127:0] scaled;
    logic [63:0]  res_mag;

    assign mag_a = req.a[63] ? 64'(-req.a) : 64'(req.a);
    assign mag_b = req.b[63] ? 64'(-req.b) : 64'(req.b);

    // lowest pending partial product: bit 0 a0*b0, 1 a0*b1, 2 a1*b0, 3 a1*b1
    always_comb
    begin
        if (mask_reg[0])
        begin
            sel = 2'd0;
        end
        else if (mask_reg[1])
        begin
            sel = 2'd1;
        end
        else if (mask_reg[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
    end

    assign mask_left = mask_reg & ~(4'b0001 << sel);
    assign op_a      = sel[1] ? mag_a_reg[63:32] : mag_a_reg[31:0];
    assign op_b      = sel[0] ? mag_b_reg[63:32] : mag_b_reg[31:0];

    always_comb
    begin
        case (pp_off_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
    end

    assign acc_sum = pp_valid_reg ? acc_reg + pp_shifted : acc_reg;
    assign scaled  = q32_reg ? (acc_reg >> RECIP_SHIFT) : (acc_reg >> FRAC_BITS);
    assign res_mag = (|scaled[127:63]) ? 64'(SAT_MAX) : {1'b0, scaled[62:0]};

    // datapath: operands, partial product and rounding accumulator
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req.start)
        begin
            mag_a_reg <= mag_a;
            mag_b_reg <= mag_b;
            neg_reg   <= req.a[63] ^ req.b[63];
            q32_reg   <= req.q32;
            acc_reg   <= req.q32 ? (128'd1 << (RECIP_SHIFT - 1))
                                 : (128'd1 << (FRAC_BITS - 1));
        end
        else
        begin
            acc_reg <= acc_sum;
        end
        pp_reg     <= 64'(op_a) * 64'(op_b);
        pp_off_reg <= 2'(sel[0]) + 2'(sel[1]);
        if (state_reg == ST_FIN)
        begin
            result_reg <= neg_reg ? -$signed(res_mag) : $signed(res_mag);
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mask_reg     <= 4'd0;
            pp_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg     <= 1'b0;
            pp_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.start)
                    begin
                        // skip partial products whose high halves are zero
                        mask_reg  <= {(|mag_a[63:32]) && (|mag_b[63:32]),
                                      |mag_a[63:32], |mag_b[63:32], 1'b1};
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    pp_valid_reg <= 1'b1;
                    mask_reg     <= mask_left;
                    if (mask_left == 4'd0)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

FILE: rtl/core/sine_taylor_series.sv
`timescale 1ns / 1ps

// Taylor-series sine in signed fixed point. Each request on the slave side carries one
// angle x in radians (32-bit signed, FRAC_BITS fraction bits, Q3.28 by default); the
// master side returns x - x^3/3! + x^5/5! - ... with term_count correction terms,
// saturated to the 32-bit range, and tlast copied through. Each term is built from the
// previous one: t_k = -round(round(t_(k-1) * x^2) * R_k), where R_k is a constant
// reciprocal of (2k)(2k+1) in 32 fraction bits, so no divider is used. All products go
// through one shared multiplier, a single 32x32 array that walks the partial products
// of a 64x64 magnitude product and then rounds half away from zero and saturates at
// +-(2^63-1). One multiply walks P of the partial products, P being 1 to 4 (1 for
// operands that fit 32 bits). An angle needs 2n + 1 multiplies, with n the active term
// count; the block takes no new request while an angle is in progress, but takes the
// next one while a finished result still waits on the master side. term_count is
// written through cfg_we/cfg_wdata (reset 5); write it only while the block is idle,
// which the block itself does not enforce; counts above MAX_TERMS (or above twelve)
// are clamped.

module sine_taylor_series #(
    parameter int MAX_TERMS = 8,
    parameter int FRAC_BITS = 28
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,     // term_count
    // angle requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // [31:0] angle
    input  logic        s_tlast,       // last_in
    // sine results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // [31:0] sine_value
    output logic        m_tlast        // last_out
);
    import stc_pkg::*;

    localparam int TERM_LIMIT = (MAX_TERMS < TABLE_LEN) ? MAX_TERMS : TABLE_LEN;
    localparam logic [3:0] TermLimit = 4'(TERM_LIMIT);

    localparam logic signed [63:0] OutMax = 64'sd2147483647;
    localparam logic signed [63:0] OutMin = -64'sd2147483648;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,    // x * x
        ST_SCALE,     // term * x^2
        ST_RECIP,     // times ratio reciprocal
        ST_OUT
    } state_t;

    state_t             state_reg;
    logic [3:0]         term_count_reg;
    logic [3:0]         n_reg;
    logic [3:0]         k_reg;
    logic               last_reg;
    logic signed [63:0] x2_reg;
    logic signed [63:0] acc_reg;
    logic               req_start_reg;
    logic               req_q32_reg;
    logic signed [63:0] req_a_reg;
    logic signed [63:0] req_b_reg;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;
    logic               m_tlast_reg;

    stc_mul_req_t       mul_req;
    stc_mul_rsp_t       rsp;
    logic signed [63:0] x_in;
    logic [3:0]         n_in;
    logic signed [63:0] neg_term;
    logic signed [64:0] sum_wide;
    logic signed [63:0] acc_sum;
    logic signed [31:0] out_value;
    logic [3:0]         k_inc;

    // multiplier request: start, q32, a, b from the top bit down
    assign mul_req = {req_start_reg, req_q32_reg, req_a_reg, req_b_reg};

    stc_mul_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign x_in     = 64'(signed'(s_tdata));
    assign n_in     = (term_count_reg > TermLimit) ? TermLimit : term_count_reg;
    assign k_inc    = k_reg + 4'd1;

    // results are symmetric, so negation never overflows
    assign neg_term = -rsp.result;
    assign sum_wide = 65'(acc_reg) + 65'(neg_term);

    // accumulator saturates symmetrically
    always_comb
    begin
        if (sum_wide > 65'(SAT_MAX))
        begin
            acc_sum = SAT_MAX;
        end
        else if (sum_wide < -65'(SAT_MAX))
        begin
            acc_sum = -SAT_MAX;
        end
        else
        begin
            acc_sum = sum_wide[63:0];
        end
    end

    // clamp to the output format
    always_comb
    begin
        if (acc_reg > OutMax)
        begin
            out_value = 32'sh7FFF_FFFF;
        end
        else if (acc_reg < OutMin)
        begin
            out_value = 32'sh8000_0000;
        end
        else
        begin
            out_value = acc_reg[31:0];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    acc_reg     <= x_in;
                    last_reg    <= s_tlast;
                    n_reg       <= n_in;
                    req_a_reg   <= x_in;
                    req_b_reg   <= x_in;
                    req_q32_reg <= 1'b0;
                end
            end
            ST_SQUARE:
            begin
                if (rsp.done)
                begin
                    // first term is x itself, still held in the accumulator
                    x2_reg      <= rsp.result;
                    k_reg       <= 4'd0;
                    req_a_reg   <= acc_reg;
                    req_b_reg   <= rsp.result;
                    req_q32_reg <= 1'b0;
                end
            end
            ST_SCALE:
            begin
                if (rsp.done)
                begin
                    req_a_reg   <= rsp.result;
                    req_b_reg   <= {32'd0, stc_ratio_recip(k_reg)};
                    req_q32_reg <= 1'b1;
                end
            end
            ST_RECIP:
            begin
                if (rsp.done)
                begin
                    acc_reg     <= acc_sum;
                    k_reg       <= k_inc;
                    req_a_reg   <= neg_term;
                    req_b_reg   <= x2_reg;
                    req_q32_reg <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= out_value;
            m_tlast_reg <= last_reg;
        end
    end

    // control: sequencer, multiplier start, output valid, configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            req_start_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            term_count_reg <= 4'd5;
        end
        else
        begin
            req_start_reg <= 1'b0;
            if (cfg_we)
            begin
                term_count_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        req_start_reg <= 1'b1;
                        state_reg     <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    if (rsp.done)
                    begin
                        if (n_reg == 4'd0)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            req_start_reg <= 1'b1;
                            state_reg     <= ST_SCALE;
                        end
                    end
                end
                ST_SCALE:
                begin
                    if (rsp.done)
                    begin
                        req_start_reg <= 1'b1;
                        state_reg     <= ST_RECIP;
                    end
                end
                ST_RECIP:
                begin
                    if (rsp.done)
                    begin
                        if (k_inc == n_reg)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            req_start_reg <= 1'b1;
                            state_reg     <= ST_SCALE;
                        end
                    end
                end
                ST_OUT:
                begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // ------------------------------------------------------------------
    // predictor and result store for the sine pipe
    // ------------------------------------------------------------------
    class sine_scoreboard;
        localparam int ANGLE_FRAC = 28;
        localparam int TERM_LIMIT = 8;
        localparam int RATIO_SHIFT = 32;
        localparam logic signed [63:0] WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

        typedef struct {
            logic [31:0] angle;
            logic [31:0] sine_value;
            logic        last_out;
        } sine_expect_t;

        logic [3:0]   term_count;
        sine_expect_t pending_q[$];
        int           errors;
        int           results_seen;

        function new();
            term_count = 4'd5;
            errors = 0;
            results_seen = 0;
        endfunction

        // (a*b) >> s on magnitudes, rounded half away from zero, clamped to +-WIDE_MAX
        function logic signed [63:0] scaled_product(logic signed [63:0] a,
                                                    logic signed [63:0] b, int s);
            logic [63:0]  ma;
            logic [63:0]  mb;
            logic [127:0] prod;
            logic [63:0]  mag;
            ma = a[63] ? (~a + 64'd1) : a;
            mb = b[63] ? (~b + 64'd1) : b;
            prod = {64'd0, ma} * {64'd0, mb};
            prod = (prod + (128'd1 << (s - 1))) >> s;
            mag = (prod > {64'd0, WIDE_MAX}) ? WIDE_MAX : prod[63:0];
            return (a[63] ^ b[63]) ? -$signed(mag) : $signed(mag);
        endfunction

        function logic signed [63:0] saturating_sum(logic signed [63:0] a,
                                                    logic signed [63:0] b);
            logic signed [64:0] s;
            s = $signed({a[63], a}) + $signed({b[63], b});
            if (s > $signed({1'b0, WIDE_MAX}))
                return WIDE_MAX;
            if (s < -$signed({1'b0, WIDE_MAX}))
                return -WIDE_MAX;
            return s[63:0];
        endfunction

        // 2^32 / ((2k+2)(2k+3)), rounded
        function logic signed [63:0] factorial_ratio(int k);
            logic [63:0] d;
            d = 64'((2 * k + 2) * (2 * k + 3));
            return $signed(((64'd1 << RATIO_SHIFT) + d / 64'd2) / d);
        endfunction

        function sine_expect_t predict(logic [31:0] angle, logic last_in);
            sine_expect_t       e;
            logic signed [63:0] x;
            logic signed [63:0] x2;
            logic signed [63:0] term;
            logic signed [63:0] acc;
            int                 n;
            x = {{32{angle[31]}}, angle};
            n = (term_count > TERM_LIMIT) ? TERM_LIMIT : int'(term_count);
            x2 = scaled_product(x, x, ANGLE_FRAC);
            term = x;
            acc = x;
            for (int k = 0; k < n; k++)
            begin
                term = scaled_product(term, x2, ANGLE_FRAC);
                term = -scaled_product(term, factorial_ratio(k), RATIO_SHIFT);
                acc = saturating_sum(acc, term);
            end
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
            else if (acc < -64'sd2147483648)
                acc = -64'sd2147483648;
            e.angle = angle;
            e.sine_value = acc[31:0];
            e.last_out = last_in;
            return e;
        endfunction

        function void note_angle(logic [31:0] angle, logic last_in);
            pending_q.push_back(predict(angle, last_in));
        endfunction

        function void check_result(logic [31:0] sine_value, logic last_out);
            sine_expect_t e;
            results_seen++;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected sine result %h last %b", $time, sine_value, last_out);
                return;
            end
            e = pending_q.pop_front();
            if (sine_value !== e.sine_value)
            begin
                errors++;
                $display("%0t: angle %h sine expected %h actual %h",
                         $time, e.angle, e.sine_value, sine_value);
            end
            if (last_out !== e.last_out)
            begin
                errors++;
                $display("%0t: angle %h last expected %b actual %b",
                         $time, e.angle, e.last_out, last_out);
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    localparam int IDLE_LIMIT = 4000;     // cycles without any handshake
    localparam int SETTLE_CYCLES = 200;
    localparam int PI_Q28 = 843314857;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 120;
    localparam int LONG_HOLD_AT = 200;    // result count that triggers the long sink stall
    localparam int LONG_HOLD_CYCLES = 500;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;

    bit          steady;      // no random gaps on either side while set
    int          idle_cycles;

    sine_scoreboard scoreboard = new();

    sine_taylor_series i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #4 clk = ~clk;

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // term count per phase: zero, the limit, above the limit, then the rest
    function automatic logic [3:0] term_plan(int phase);
        case (phase)
            0:       return 4'd0;
            1:       return 4'd8;
            2:       return 4'd15;
            3:       return 4'd1;
            4:       return 4'd2;
            5:       return 4'd3;
            6:       return 4'd4;
            7:       return 4'd6;
            8:       return 4'd7;
            9:       return 4'd9;
            10:      return 4'd12;
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    // zero, one lsb, format limits, +-1.0, +-pi/2, +-pi, 2pi, +-4.0, bit patterns
    function automatic logic [31:0] corner_angle(int idx);
        case (idx)
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return 32'h1000_0000;
            6:       return 32'hF000_0000;
            7:       return 32'd421657428;
            8:       return -32'd421657428;
            9:       return 32'd843314857;
            10:      return -32'd843314857;
            11:      return 32'd1686629713;
            12:      return 32'h4000_0000;
            13:      return 32'hC000_0000;
            14:      return 32'h0000_8000;
            15:      return 32'h5555_5555;
            16:      return 32'hAAAA_AAAA;
            17:      return 32'h7FFF_FFFE;
            default: return 32'h8000_0001;
        endcase
    endfunction

    // mostly the principal range, plus small, large and raw 32-bit angles
    function automatic logic [31:0] random_angle();
        int          kind;
        logic [31:0] mag;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: return 32'(int'($urandom_range(0, 2 * PI_Q28)) - PI_Q28);
            4, 5:       return $urandom();
            6:          mag = $urandom_range(0, 32'h0001_0000);
            7, 8:       mag = $urandom_range(PI_Q28, 32'h7FFF_FFFF);
            default:    mag = $urandom_range(0, 2 * PI_Q28);
        endcase
        return ($urandom_range(0, 1) != 0) ? -mag : mag;
    endfunction

    // one angle request; called and returns at a falling edge
    task automatic send_angle(input logic [31:0] angle, input logic last_in);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= angle;
        s_tlast <= last_in;
        do
            @(posedge clk);
        while (!s_tready);
        scoreboard.note_angle(angle, last_in);
        @(negedge clk);
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // sender pause until every sine result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(negedge clk);
    endtask

    // register writes only happen while the pipe is empty
    task automatic write_term_count(input logic [3:0] count);
        cfg_we <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we <= 1'b0;
        scoreboard.term_count = count;
    endtask

    // result side: random backpressure, plus one long hold so the pipe fills up
    initial
    begin : result_sink
        int hold;
        bit long_hold_done;
        hold = 0;
        long_hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && scoreboard.results_seen >= LONG_HOLD_AT)
            begin
                hold = LONG_HOLD_CYCLES;
                long_hold_done = 1;
            end
            else if (hold == 0 && !steady)
                hold = pick_gap();
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            scoreboard.check_result(m_tdata, m_tlast);
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 4'd0;
        s_tvalid = 1'b0;
        s_tdata = 32'd0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        steady = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corner angles at the reset term count of five
        for (int i = 0; i < 19; i++)
            send_angle(corner_angle(i), i[0]);
        drain_results();

        // random phases, each under its own term count; every fourth runs without random gaps
        for (int p = 0; p < PHASES; p++)
        begin
            write_term_count(term_plan(p));
            steady = (p % 4 == 1);
            repeat (PHASE_ITEMS)
                send_angle(random_angle(), $urandom_range(0, 3) == 0);
            drain_results();
        end
        steady = 1'b0;

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (scoreboard.errors == 0 && scoreboard.pending() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
